[rtl/motor_motion_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Motor motion sequencer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MOTOR_MOTION_SEQUENCER_DEFINES_SVH
`define MOTOR_MOTION_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define MMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mms assertion failed");

// next-cycle implication
`define MMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mms assertion failed");

`endif

[rtl/mms_pkg.sv]
// ----------------------------------------------------------------------------
// mms_pkg
// Types and codes shared by the motor motion sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mms_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned IN_ITEM_W   = 39;
  localparam int unsigned OUT_ITEM_W  = 9;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic [15:0] COAST_RST   = 16'd100;

  typedef enum logic [3:0] {
    OP_BRAKE       = 4'd0,
    OP_STOP        = 4'd1,
    OP_OPEN_START  = 4'd2,
    OP_SOFT_OPEN   = 4'd3,
    OP_OPEN        = 4'd4,
    OP_CLOSE_START = 4'd5,
    OP_SOFT_CLOSE  = 4'd6,
    OP_CLOSE       = 4'd7,
    OP_SHORT_BRAKE = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    STEP_DRIVE  = 2'd0,
    STEP_WAIT   = 2'd1,
    STEP_BRAKE  = 2'd2,
    STEP_FINISH = 2'd3
  } step_e;

  localparam logic [0:0] REG_COAST = 1'b0;

  // packed so that op sits in the lowest bits
  typedef struct packed {
    logic [15:0] wait_sec_limit;
    logic [15:0] wait_ms_limit;
    logic        tick_sec;
    logic        tick_ms;
    logic        restart;
    logic [3:0]  op;
  } in_t;

  typedef struct packed {
    logic pwm;
    logic pump;
    logic cw;
    logic ccw;
  } drv_t;

  typedef struct packed {
    logic [1:0] step_now;
    logic       done_res;
    logic       clear_pulse_count;
    logic       soft_start;
    logic       dir_ccw;
    logic       dir_cw;
    logic       pump_on;
    logic       pwm_on;
  } res_t;

endpackage

`default_nettype wire

[rtl/mms_cfg.sv]
// ----------------------------------------------------------------------------
// mms_cfg
// APB register file holding the brake coast time.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_cfg
  import mms_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  output      logic [15:0]           coast_ms_o
);

  logic [15:0] coast_q, coast_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_COAST);

  always_comb begin
    coast_d = coast_q;
    if (wr_en) begin
      coast_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coast_q <= COAST_RST;
    end else begin
      coast_q <= coast_d;
    end
  end

  assign prdata     = (paddr[2] == REG_COAST) ? {16'd0, coast_q} : 32'd0;
  assign coast_ms_o = coast_q;

endmodule

`default_nettype wire

[rtl/mms_core.sv]
// ----------------------------------------------------------------------------
// mms_core
// Sequencer state and the combinational step logic for one motion word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "motor_motion_sequencer_defines.svh"

module mms_core
  import mms_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire in_t         item_i,
  input  wire logic [15:0] coast_ms_i,
  output      res_t        res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [1:0]            step_q, step_d, step_base;
  logic [TIMER_BITS-1:0] ms_q, ms_d, ms_inc;
  logic [TIMER_BITS-1:0] sec_q, sec_d, sec_inc;
  drv_t                  drv_q, drv_d, pat;
  logic                  soft_flag, clr, done, can_finish;
  logic                  coast_hit, lim_hit;

  assign ms_inc  = (item_i.tick_ms && (ms_q != '1)) ? ms_q + 1'b1 : ms_q;
  assign sec_inc = (item_i.tick_sec && (sec_q != '1)) ? sec_q + 1'b1 : sec_q;

  assign coast_hit = CMP_W'(ms_inc) >= CMP_W'(coast_ms_i);
  assign lim_hit   = (CMP_W'(ms_inc) >= CMP_W'(item_i.wait_ms_limit)) &&
                     (CMP_W'(sec_inc) >= CMP_W'(item_i.wait_sec_limit));

  assign step_base = item_i.restart ? STEP_DRIVE : step_q;

  // per-motion drive pattern and flags
  always_comb begin
    pat        = '{pwm: 1'b0, pump: 1'b1, cw: 1'b0, ccw: 1'b0};
    soft_flag  = 1'b0;
    clr        = 1'b0;
    can_finish = 1'b1;
    case (item_i.op)
      OP_BRAKE: begin
        clr = 1'b1;
        if (drv_q.cw && !drv_q.ccw) begin
          pat.cw = 1'b1;
        end else if (drv_q.ccw && !drv_q.cw) begin
          pat.ccw = 1'b1;
        end
      end
      OP_STOP: begin
        pat.pump   = 1'b0;
        clr        = 1'b1;
        can_finish = 1'b0;
      end
      OP_OPEN_START: begin
        pat.cw = 1'b1;
        clr    = 1'b1;
      end
      OP_SOFT_OPEN: begin
        pat.pwm   = 1'b1;
        pat.cw    = 1'b1;
        soft_flag = 1'b1;
      end
      OP_OPEN: begin
        pat.pwm = 1'b1;
        pat.cw  = 1'b1;
      end
      OP_CLOSE_START: begin
        pat.ccw = 1'b1;
        clr     = 1'b1;
      end
      OP_SOFT_CLOSE: begin
        pat.pwm   = 1'b1;
        pat.ccw   = 1'b1;
        soft_flag = 1'b1;
      end
      OP_CLOSE: begin
        pat.pwm = 1'b1;
        pat.ccw = 1'b1;
      end
      OP_SHORT_BRAKE: begin
        clr        = 1'b1;
        can_finish = 1'b0;
      end
      default: begin
        can_finish = 1'b0;
      end
    endcase
  end

  // step sequencing
  always_comb begin
    step_d = step_base;
    ms_d   = ms_inc;
    sec_d  = sec_inc;
    drv_d  = drv_q;
    done   = 1'b0;
    if (item_i.op == OP_BRAKE) begin
      case (step_base)
        STEP_DRIVE: begin
          drv_d  = pat;
          ms_d   = '0;
          sec_d  = '0;
          step_d = STEP_WAIT;
        end
        STEP_WAIT: begin
          if (coast_hit) begin
            step_d = STEP_BRAKE;
          end
        end
        STEP_BRAKE: begin
          drv_d  = '{pwm: 1'b0, pump: 1'b1, cw: 1'b0, ccw: 1'b0};
          ms_d   = '0;
          sec_d  = '0;
          step_d = STEP_FINISH;
        end
        default: begin
          done = coast_hit;
        end
      endcase
    end else if (item_i.op <= OP_SHORT_BRAKE) begin
      case (step_base)
        STEP_DRIVE: begin
          drv_d  = pat;
          ms_d   = '0;
          sec_d  = '0;
          step_d = STEP_WAIT;
        end
        STEP_WAIT: begin
          done = can_finish && lim_hit;
        end
        default: begin
          step_d = STEP_DRIVE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_DRIVE;
      ms_q   <= '0;
      sec_q  <= '0;
      drv_q  <= '0;
    end else if (en_i) begin
      step_q <= step_d;
      ms_q   <= ms_d;
      sec_q  <= sec_d;
      drv_q  <= drv_d;
    end
  end

  assign res_o = '{
    step_now:          step_d,
    done_res:          done,
    clear_pulse_count: clr && (item_i.op <= OP_SHORT_BRAKE),
    soft_start:        soft_flag,
    dir_ccw:           drv_d.ccw,
    dir_cw:            drv_d.cw,
    pump_on:           drv_d.pump,
    pwm_on:            drv_d.pwm
  };

  `MMS_ASSERT_NXT(a_drive_clears_wait, clk_i, rst_ni,
    en_i && (step_base == STEP_DRIVE) && (item_i.op <= OP_SHORT_BRAKE),
    (ms_q == '0) && (sec_q == '0))
  `MMS_ASSERT_IMP(a_done_step, clk_i, rst_ni, en_i && done,
    (step_d == STEP_WAIT) || (step_d == STEP_FINISH))
  `MMS_ASSERT_NXT(a_idle_holds, clk_i, rst_ni, !en_i,
    $stable(step_q) && $stable(ms_q) && $stable(drv_q))
  `MMS_ASSERT_IMP(a_one_dir, clk_i, rst_ni, 1'b1, !(drv_q.cw && drv_q.ccw))

endmodule

`default_nettype wire

[rtl/motor_motion_sequencer.sv]
// ----------------------------------------------------------------------------
// motor_motion_sequencer
// Timed PWM, pump and direction sequencing for a DC motor, one step per word.
// ----------------------------------------------------------------------------
// Each accepted input word runs one step of the selected motion against the
// sequencer state and yields one result word. A word is accepted every clock
// cycle while m_axis_tready does not hold back the result side; the result
// passes the input register, then the result register, and the state update
// of one word is complete before the next word reaches the step logic. The
// result register frees the input side while a result waits. Brake coast
// time is set over APB at address 0x0 and resets to 100 ms.
`default_nettype none

module motor_motion_sequencer
  import mms_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // op[3:0], restart[4], tick_ms[5], tick_sec[6], wait_ms_limit[22:7],
  // wait_sec_limit[38:23], zero pad[39]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // pwm_on[0], pump_on[1], dir_cw[2], dir_ccw[3], soft_start[4],
  // clear_pulse_count[5], done_res[6], step_now[8:7], zero pad[15:9]
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]            pwdata,
  output      logic [31:0]            prdata,
  output      logic                   pready
);

  logic        in_vld_q, in_vld_d;
  in_t         in_q;
  logic        out_vld_q, out_vld_d;
  res_t        out_q, res;
  logic        adv, s_fire;
  logic [15:0] coast_ms;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= in_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    end
    if (adv) begin
      out_q <= res;
    end
  end

  mms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .coast_ms_o (coast_ms)
  );

  mms_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .item_i     (in_q),
    .coast_ms_i (coast_ms),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_ITEM_W){1'b0}}, out_q};

endmodule

`default_nettype wire

[sim/motor_motion_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_motion_sequencer_tb
// Self-checking bench for the motor motion sequencer.
// ----------------------------------------------------------------------------
// Motion words are queued by the stimulus process and driven by a stream
// driver at the falling edge. A monitor predicts the result of every accepted
// word with a behavioral copy of the sequencer and checks the results field
// by field. Brake coast time is changed over APB between phases while the
// block is idle.

module motor_motion_sequencer_tb;
  import mms_pkg::*;

  localparam int unsigned TIMER_BITS = 16;
  localparam int          CYC_LIMIT  = 1_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  motor_motion_sequencer #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // sequencer model state
  logic [15:0]           coast_ms = COAST_RST;
  step_e                 step_cnt = STEP_DRIVE;
  logic [TIMER_BITS-1:0] ms_cnt   = '0;
  logic [TIMER_BITS-1:0] sec_cnt  = '0;
  drv_t                  drv      = '0;

  in_t  motion_q[$];
  res_t result_q[$];
  int   n_queued    = 0;
  int   n_accepted  = 0;
  int   n_fail      = 0;
  int   cyc         = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   rx_hold     = 0;
  bit   in_fired    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t motion_step(in_t w);
    res_t       r;
    logic [3:0] nd;
    logic       fin;
    logic       act;
    r   = '0;
    nd  = 4'b0100;
    fin = 1'b1;
    act = 1'b1;
    if (w.tick_ms && ms_cnt != '1) ms_cnt = ms_cnt + 1'b1;
    if (w.tick_sec && sec_cnt != '1) sec_cnt = sec_cnt + 1'b1;
    if (w.restart) step_cnt = STEP_DRIVE;
    case (w.op)
      OP_BRAKE:       r.clear_pulse_count = 1'b1;
      OP_STOP:        begin nd = 4'b0000; r.clear_pulse_count = 1'b1; fin = 1'b0; end
      OP_OPEN_START:  begin nd = 4'b0110; r.clear_pulse_count = 1'b1; end
      OP_SOFT_OPEN:   begin nd = 4'b1110; r.soft_start = 1'b1; end
      OP_OPEN:        nd = 4'b1110;
      OP_CLOSE_START: begin nd = 4'b0101; r.clear_pulse_count = 1'b1; end
      OP_SOFT_CLOSE:  begin nd = 4'b1101; r.soft_start = 1'b1; end
      OP_CLOSE:       nd = 4'b1101;
      OP_SHORT_BRAKE: begin r.clear_pulse_count = 1'b1; fin = 1'b0; end
      default:        act = 1'b0;
    endcase
    if (w.op == OP_BRAKE) begin
      case (step_cnt)
        STEP_DRIVE: begin
          // coast keeps a direction only if exactly one is set
          drv = {1'b0, 1'b1, drv.cw & ~drv.ccw, drv.ccw & ~drv.cw};
          ms_cnt   = '0;
          sec_cnt  = '0;
          step_cnt = STEP_WAIT;
        end
        STEP_WAIT: begin
          if (ms_cnt >= coast_ms) step_cnt = STEP_BRAKE;
        end
        STEP_BRAKE: begin
          drv      = 4'b0100;
          ms_cnt   = '0;
          sec_cnt  = '0;
          step_cnt = STEP_FINISH;
        end
        default: begin
          if (ms_cnt >= coast_ms) r.done_res = 1'b1;
        end
      endcase
    end else if (act) begin
      case (step_cnt)
        STEP_DRIVE: begin
          drv      = nd;
          ms_cnt   = '0;
          sec_cnt  = '0;
          step_cnt = STEP_WAIT;
        end
        STEP_WAIT: begin
          if (fin && ms_cnt >= w.wait_ms_limit && sec_cnt >= w.wait_sec_limit)
            r.done_res = 1'b1;
        end
        default: step_cnt = STEP_DRIVE;
      endcase
    end
    r.pwm_on   = drv.pwm;
    r.pump_on  = drv.pump;
    r.dir_cw   = drv.cw;
    r.dir_ccw  = drv.ccw;
    r.step_now = step_cnt;
    return r;
  endfunction

  task automatic chk(string nm, logic [1:0] e, logic [1:0] a);
    if (e !== a) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
    end
  endtask

  // stream driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fired) begin
        if (motion_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_axis_tdata  <= {1'b0, motion_q.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      in_fired = 1'b0;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : mon
    res_t e;
    res_t a;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_fired = 1'b1;
        n_accepted++;
        result_q.push_back(motion_step(in_t'(s_axis_tdata[IN_ITEM_W-1:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        a = res_t'(m_axis_tdata[OUT_ITEM_W-1:0]);
        if (result_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected word, expected none, got %h", $time, m_axis_tdata);
        end else begin
          e = result_q.pop_front();
          chk("pwm_on", e.pwm_on, a.pwm_on);
          chk("pump_on", e.pump_on, a.pump_on);
          chk("dir_cw", e.dir_cw, a.dir_cw);
          chk("dir_ccw", e.dir_ccw, a.dir_ccw);
          chk("soft_start", e.soft_start, a.soft_start);
          chk("clear_pulse_count", e.clear_pulse_count, a.clear_pulse_count);
          chk("done_res", e.done_res, a.done_res);
          chk("step_now", e.step_now, a.step_now);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_word(logic [3:0] op, logic rs, logic tms, logic tsec,
                          logic [15:0] ml, logic [15:0] sl);
    in_t w;
    w.op             = op;
    w.restart        = rs;
    w.tick_ms        = tms;
    w.tick_sec       = tsec;
    w.wait_ms_limit  = ml;
    w.wait_sec_limit = sl;
    motion_q.push_back(w);
    n_queued++;
  endtask

  task automatic add_noise();
    add_word(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic add_motion();
    logic [3:0]  op;
    logic [3:0]  cur;
    logic [15:0] ml;
    logic [15:0] sl;
    int          len;
    int          pm;
    int          ps;
    op = 4'($urandom_range(0, 8));
    if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(9, 15));
    ml = 16'($urandom_range(0, 6));
    sl = 16'($urandom_range(0, 2));
    pm = $urandom_range(20, 100);
    ps = $urandom_range(10, 80);
    len = $urandom_range(2, 14);
    if (op == OP_BRAKE) begin
      pm = $urandom_range(70, 100);
      if (coast_ms <= 120) len = (2 * coast_ms * 100) / pm + $urandom_range(2, 6);
    end
    for (int i = 0; i < len; i++) begin
      cur = op;
      if (i != 0 && $urandom_range(0, 29) == 0) cur = 4'($urandom_range(0, 8));
      add_word(cur,
               (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0),
               $urandom_range(0, 99) < pm, $urandom_range(0, 99) < ps,
               ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : ml,
               ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : sl);
    end
  endtask

  task automatic add_random(int n);
    int stop_at;
    stop_at = n_queued + n;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_motion();
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || result_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
    #1;
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(logic [APB_ADDR_W-1:0] addr, logic [31:0] exp_val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== exp_val[15:0]) begin
      n_fail++;
      $display("%0t: coast readback mismatch, expected %0d, got %0d",
               $time, exp_val[15:0], rd[15:0]);
    end
  endtask

  task automatic set_coast(logic [15:0] v);
    apb_write({REG_COAST, 2'b00}, {16'd0, v});
    coast_ms = v;
    apb_check({REG_COAST, 2'b00}, {16'd0, v});
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    apb_check({REG_COAST, 2'b00}, {16'd0, COAST_RST});

    // directed words, default coast time
    tx_idle_pct = 37;
    rx_idle_pct = 54;
    add_word(OP_OPEN, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_OPEN, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_OPEN, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    add_word(OP_STOP, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
    add_word(OP_STOP, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0);
    add_word(OP_SHORT_BRAKE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_SHORT_BRAKE, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0);
    add_word(4'd9, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0);
    add_word(4'd15, 1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
    add_word(OP_SOFT_OPEN, 1'b1, 1'b0, 1'b0, 16'd1, 16'd1);
    add_word(OP_SOFT_OPEN, 1'b0, 1'b1, 1'b1, 16'd1, 16'd1);
    add_word(OP_SOFT_CLOSE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_CLOSE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_BRAKE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_BRAKE, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0);
    add_word(OP_OPEN_START, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_BRAKE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_CLOSE_START, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_CLOSE_START, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_STOP, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_BRAKE, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    add_word(OP_OPEN, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0);
    wait_idle();

    set_coast(16'd3);
    add_random(600);
    rx_hold = 400;
    wait_idle();

    tx_idle_pct = 54;
    rx_idle_pct = 37;
    set_coast(16'd0);
    add_random(500);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_coast(16'hFFFF);
    add_random(300);
    wait_idle();

    set_coast(16'd1);
    add_random(300);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (n_fail == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
